// File: design/rcp_pkg.sv
package rcp_pkg;

  localparam int NUM_POINTS_DEFAULT = 8;

  localparam int ANGLE_W  = 16;
  localparam int RADIUS_W = 10;
  localparam int STEP_W   = 16;
  localparam int ZP_W     = 11;
  localparam int POS_W    = 19;
  localparam int IDX_W    = 3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZPLANE = 2'd2;

  localparam logic [RADIUS_W-1:0]     RADIUS_RESET = 10'd100;
  localparam logic [STEP_W-1:0]       STEP_RESET   = 16'd1;
  localparam logic signed [ZP_W-1:0]  ZPLANE_RESET = 11'sd100;

  localparam int FULL_TURN     = 36000;
  localparam int QUARTER_TURN  = 9000;
  localparam int RESET_SPACING = 4500;

  // 2^30 = Z_SCALE * 9000 + Z_FRAC
  localparam int Z_SCALE  = 119304;
  localparam int Z_FRAC   = 5824;
  localparam int Z_BIAS   = 4500;
  localparam int DIV_BITS = 13;
  localparam int REM_W    = 27;
  localparam int RESID_W  = 14;
  localparam int ZBASE_W  = 31;

  // floor(n / 9000) = ((n >> Z_PRESHIFT) * Z_RECIP) >> Z_RECIP_SHIFT for n < 2^REM_W
  localparam int Z_PRESHIFT    = 3;
  localparam int Z_RECIP       = 15270995;
  localparam int Z_RECIP_SHIFT = 34;
  localparam int QPROD_W       = 48;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_W     = 34;
  localparam int PROD_W       = 45;
  localparam int GAIN_Q30     = 652032874;
  localparam int POS_LIMIT    = 261888;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [ANGLE_W-1:0] angle;
    logic               last;
  } point_job_t;

  function automatic logic [29:0] atan_entry(input logic [3:0] i);
    logic [29:0] t;
    unique case (i)
      4'd0:  t = 30'h20000000;
      4'd1:  t = 30'h12E4051E;
      4'd2:  t = 30'h09FB385B;
      4'd3:  t = 30'h051111D4;
      4'd4:  t = 30'h028B0D43;
      4'd5:  t = 30'h0145D7E1;
      4'd6:  t = 30'h00A2F61E;
      4'd7:  t = 30'h00517C55;
      4'd8:  t = 30'h0028BE53;
      4'd9:  t = 30'h00145F2F;
      4'd10: t = 30'h000A2F98;
      4'd11: t = 30'h000517CC;
      4'd12: t = 30'h00028BE6;
      4'd13: t = 30'h000145F3;
      4'd14: t = 30'h0000A2FA;
      default: t = 30'h0000517D;
    endcase
    return t;
  endfunction

endpackage

// File: design/rcp_channels.sv
interface rcp_tick_if;
  logic valid;
  logic ready;
  logic advance;
  modport source (output valid, output advance, input ready);
  modport sink (input valid, input advance, output ready);
endinterface

interface rcp_point_if;
  logic                              valid;
  logic                              ready;
  logic [rcp_pkg::IDX_W-1:0]         point_index;
  logic signed [rcp_pkg::POS_W-1:0]  x_pos;
  logic signed [rcp_pkg::POS_W-1:0]  y_pos;
  logic signed [rcp_pkg::ZP_W-1:0]   z_pos;
  logic                              last_point;
  modport source (output valid, output point_index, output x_pos, output y_pos,
                  output z_pos, output last_point, input ready);
  modport sink (input valid, input point_index, input x_pos, input y_pos,
                input z_pos, input last_point, output ready);
endinterface

// File: design/rcp_queue.sv
module rcp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  rcp_pkg::point_job_t push_job,
  output logic                pop_valid,
  input  logic                pop_ready,
  output rcp_pkg::point_job_t pop_job
);

  rcp_pkg::point_job_t slots [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count + 2'(push) - 2'(pop);
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

endmodule

// File: design/rcp_front.sv
module rcp_front #(
  parameter int NUM_POINTS = rcp_pkg::NUM_POINTS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  rcp_tick_if.sink                    tick,
  input  logic [rcp_pkg::STEP_W-1:0]  angle_step,
  output logic                        push_valid,
  input  logic                        push_ready,
  output rcp_pkg::point_job_t         push_job
);

  localparam int PIDX_W = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam logic [PIDX_W-1:0] LAST_IDX = PIDX_W'(NUM_POINTS - 1);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_READ = 2'd1;
  localparam logic [1:0] F_UPD  = 2'd2;

  logic [1:0]                   state;
  logic [PIDX_W-1:0]            idx;
  logic                         adv;
  logic [NUM_POINTS-1:0]        written;
  logic [rcp_pkg::ANGLE_W-1:0]  angle_mem [NUM_POINTS];
  logic [rcp_pkg::ANGLE_W-1:0]  rd_data;
  logic                         rd_written;
  logic [rcp_pkg::IDX_W-1:0]    idx3;
  logic [rcp_pkg::ANGLE_W-1:0]  reset_angle;
  logic [rcp_pkg::ANGLE_W-1:0]  cur;
  logic [rcp_pkg::ANGLE_W:0]    sum;
  logic [rcp_pkg::ANGLE_W-1:0]  angle_next;
  logic                         is_last;
  logic                         push;

  assign tick.ready  = (state == F_IDLE);
  assign idx3        = rcp_pkg::IDX_W'(idx);
  assign reset_angle = rcp_pkg::ANGLE_W'(idx3 * 16'(rcp_pkg::RESET_SPACING));
  assign cur         = rd_written ? rd_data : reset_angle;
  assign sum         = {1'b0, cur} + {1'b0, angle_step};
  assign is_last     = (idx == LAST_IDX);

  always_comb begin
    if (!adv) begin
      angle_next = cur;
    end else if (sum >= 17'(rcp_pkg::FULL_TURN)) begin
      angle_next = '0;
    end else begin
      angle_next = sum[rcp_pkg::ANGLE_W-1:0];
    end
  end

  assign push_valid     = (state == F_UPD);
  assign push_job.index = idx3;
  assign push_job.angle = angle_next;
  assign push_job.last  = is_last;
  assign push           = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      idx     <= '0;
      adv     <= 1'b0;
      written <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (tick.valid) begin
            adv   <= tick.advance;
            idx   <= '0;
            state <= F_READ;
          end
        end
        F_READ: begin
          state <= F_UPD;
        end
        F_UPD: begin
          if (push) begin
            if (adv) written[idx] <= 1'b1;
            if (is_last) begin
              state <= F_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= F_READ;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_READ) begin
      rd_data    <= angle_mem[idx];
      rd_written <= written[idx];
    end
    if (push && adv) angle_mem[idx] <= angle_next;
  end

endmodule

// File: design/rcp_back.sv
module rcp_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  rcp_pkg::point_job_t               pop_job,
  input  logic [rcp_pkg::RADIUS_W-1:0]      radius,
  input  logic signed [rcp_pkg::ZP_W-1:0]   z_plane,
  rcp_point_if.source                       point
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_INIT = 3'd3;
  localparam logic [2:0] ST_ROT  = 3'd4;
  localparam logic [2:0] ST_MAP  = 3'd5;
  localparam logic [2:0] ST_MUL  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  localparam int CW = rcp_pkg::CORDIC_W;
  localparam int PW = rcp_pkg::PROD_W;

  logic [2:0]                          state;
  logic [3:0]                          step;
  logic                                out_valid;
  logic                                load_out;

  logic [rcp_pkg::IDX_W-1:0]           job_index;
  logic                                job_last;
  logic [1:0]                          quad;
  logic [rcp_pkg::RESID_W-1:0]         resid;
  logic [rcp_pkg::REM_W-1:0]           rem;
  logic [rcp_pkg::ZBASE_W-1:0]         zbase;
  logic [rcp_pkg::DIV_BITS-1:0]        quo;
  logic signed [CW-1:0]                x;
  logic signed [CW-1:0]                y;
  logic signed [CW-1:0]                z;
  logic signed [CW-1:0]                xc;
  logic signed [CW-1:0]                yc;
  logic signed [PW-1:0]                xprod;
  logic signed [PW-1:0]                yprod;
  logic [rcp_pkg::IDX_W-1:0]           out_index;
  logic signed [rcp_pkg::POS_W-1:0]    out_x;
  logic signed [rcp_pkg::POS_W-1:0]    out_y;
  logic                                out_last;

  logic [1:0]                          in_quad;
  logic [rcp_pkg::RESID_W-1:0]         in_resid;
  logic [rcp_pkg::QPROD_W-1:0]         quo_prod;
  logic signed [CW-1:0]                dx;
  logic signed [CW-1:0]                dy;
  logic signed [CW-1:0]                atan_s;
  logic signed [rcp_pkg::RADIUS_W:0]   radius_s;

  function automatic logic signed [rcp_pkg::POS_W-1:0] round_sat(
    input logic signed [PW-1:0] p
  );
    logic signed [PW-1:0] v;
    v = (p + PW'(64'sd2097152)) >>> 22;
    if (v > PW'(rcp_pkg::POS_LIMIT)) begin
      v = PW'(rcp_pkg::POS_LIMIT);
    end else if (v < -PW'(rcp_pkg::POS_LIMIT)) begin
      v = -PW'(rcp_pkg::POS_LIMIT);
    end
    return v[rcp_pkg::POS_W-1:0];
  endfunction

  always_comb begin
    priority if (pop_job.angle >= 16'(3 * rcp_pkg::QUARTER_TURN)) begin
      in_quad  = 2'd3;
      in_resid = rcp_pkg::RESID_W'(pop_job.angle - 16'(3 * rcp_pkg::QUARTER_TURN));
    end else if (pop_job.angle >= 16'(2 * rcp_pkg::QUARTER_TURN)) begin
      in_quad  = 2'd2;
      in_resid = rcp_pkg::RESID_W'(pop_job.angle - 16'(2 * rcp_pkg::QUARTER_TURN));
    end else if (pop_job.angle >= 16'(rcp_pkg::QUARTER_TURN)) begin
      in_quad  = 2'd1;
      in_resid = rcp_pkg::RESID_W'(pop_job.angle - 16'(rcp_pkg::QUARTER_TURN));
    end else begin
      in_quad  = 2'd0;
      in_resid = rcp_pkg::RESID_W'(pop_job.angle);
    end
  end

  assign quo_prod  = rcp_pkg::QPROD_W'(rem >> rcp_pkg::Z_PRESHIFT)
                     * rcp_pkg::QPROD_W'(rcp_pkg::Z_RECIP);
  assign dx        = y >>> step;
  assign dy        = x >>> step;
  assign atan_s    = $signed(CW'(rcp_pkg::atan_entry(step)));
  assign radius_s  = $signed({1'b0, radius});
  assign pop_ready = (state == ST_IDLE);
  assign load_out  = (state == ST_OUT) && (!out_valid || point.ready);

  assign point.valid       = out_valid;
  assign point.point_index = out_index;
  assign point.x_pos       = out_x;
  assign point.y_pos       = out_y;
  assign point.z_pos       = z_plane;
  assign point.last_point  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (point.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (pop_valid) state <= ST_PREP;
        ST_PREP: state <= ST_DIV;
        ST_DIV:  state <= ST_INIT;
        ST_INIT: begin
          step  <= '0;
          state <= ST_ROT;
        end
        ST_ROT: begin
          step <= step + 1'b1;
          if (step == 4'(rcp_pkg::CORDIC_STEPS - 1)) state <= ST_MAP;
        end
        ST_MAP:  state <= ST_MUL;
        ST_MUL:  state <= ST_OUT;
        ST_OUT:  if (load_out) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        job_index <= pop_job.index;
        job_last  <= pop_job.last;
        quad      <= in_quad;
        resid     <= in_resid;
      end
      ST_PREP: begin
        rem   <= rcp_pkg::REM_W'({13'd0, resid} * rcp_pkg::REM_W'(rcp_pkg::Z_FRAC))
                 + rcp_pkg::REM_W'(rcp_pkg::Z_BIAS);
        zbase <= rcp_pkg::ZBASE_W'({17'd0, resid})
                 * rcp_pkg::ZBASE_W'(rcp_pkg::Z_SCALE);
      end
      ST_DIV: begin
        quo <= quo_prod[rcp_pkg::Z_RECIP_SHIFT +: rcp_pkg::DIV_BITS];
      end
      ST_INIT: begin
        x <= CW'(rcp_pkg::GAIN_Q30);
        y <= '0;
        z <= $signed({3'b000, zbase + rcp_pkg::ZBASE_W'(quo)});
      end
      ST_ROT: begin
        if (!z[CW-1]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - atan_s;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + atan_s;
        end
      end
      ST_MAP: begin
        unique case (quad)
          2'd0: begin xc <= x;  yc <= y;  end
          2'd1: begin xc <= -y; yc <= x;  end
          2'd2: begin xc <= -x; yc <= -y; end
          default: begin xc <= y; yc <= -x; end
        endcase
      end
      ST_MUL: begin
        xprod <= radius_s * xc;
        yprod <= radius_s * yc;
      end
      default: begin
        if (load_out) begin
          out_index <= job_index;
          out_last  <= job_last;
          out_x     <= round_sat(xprod);
          out_y     <= round_sat(yprod);
        end
      end
    endcase
  end

endmodule

// File: design/rotating_circle_points_top.sv
// Ring of points turning on a circle, reported as fixed-point positions.
// tick channel: one item per frame; advance=1 steps every angle by
// angle_step (wrapping to zero at 360 degrees) before reporting, advance=0
// only reports. point channel: NUM_POINTS items per tick, in point order,
// x_pos/y_pos = radius * cos/sin (signed, 8 fraction bits), z_pos = z_plane,
// last_point on the final one.
// Configuration: cfg_we with cfg_index 0 radius, 1 angle_step, 2 z_plane;
// other indexes are dropped. Write only while no tick is in flight.
// Processing: each point passes through the shared back unit (angle scaling
// by a reciprocal multiply, then 16 CORDIC iterations, then map, multiply
// and round). The back unit takes a new point only once it has handed the
// previous one to the output register.
// The next tick is taken once the front has queued the last point.
// Reset: angles return to 45-degree spacings, registers to their defaults,
// no point is pending. A stalled receiver holds the output register; the
// two-entry queue then fills and the front stops until room frees up.
module rotating_circle_points_top #(
  parameter int NUM_POINTS = rcp_pkg::NUM_POINTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  rcp_tick_if.sink                        tick,
  rcp_point_if.source                     point,
  input  logic                            cfg_we,
  input  logic [rcp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rcp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [rcp_pkg::IDX_W-1:0] LAST_IDX3 = rcp_pkg::IDX_W'((NUM_POINTS - 1) % 8);

  logic [rcp_pkg::RADIUS_W-1:0]     radius;
  logic [rcp_pkg::STEP_W-1:0]       angle_step;
  logic signed [rcp_pkg::ZP_W-1:0]  z_plane;

  logic                 push_valid;
  logic                 push_ready;
  rcp_pkg::point_job_t  push_job;
  logic                 pop_valid;
  logic                 pop_ready;
  rcp_pkg::point_job_t  pop_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= rcp_pkg::RADIUS_RESET;
      angle_step <= rcp_pkg::STEP_RESET;
      z_plane    <= rcp_pkg::ZPLANE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcp_pkg::CFG_RADIUS: radius     <= cfg_data[rcp_pkg::RADIUS_W-1:0];
        rcp_pkg::CFG_STEP:   angle_step <= cfg_data[rcp_pkg::STEP_W-1:0];
        rcp_pkg::CFG_ZPLANE: z_plane    <= $signed(cfg_data[rcp_pkg::ZP_W-1:0]);
        default: ;
      endcase
    end
  end

  rcp_front #(
    .NUM_POINTS (NUM_POINTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .angle_step (angle_step),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  rcp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  rcp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .radius    (radius),
    .z_plane   (z_plane),
    .point     (point)
  );

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    tick.valid && tick.ready |=> !tick.ready)
    else $error("tick taken while previous tick still being queued");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    point.valid && point.last_point |-> point.point_index == LAST_IDX3)
    else $error("last point marker on wrong point index");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> !point.valid && tick.ready)
    else $error("pending point or busy front after reset");

endmodule
